### design/dpf_pkg.sv
// Shared types, constants and helpers of the duplicate packet filter.
package dpf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HELD_W      = 5;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [31:0] packet_id;
        logic [31:0] source_id;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [31:0] packet_id;
        logic [31:0] source_id;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic              is_duplicate;
        logic [HELD_W-1:0] entries_held;
        logic              table_overflow;
    } result_t;

    // Summary of one pass over the table, handed from the scan unit to control
    typedef struct packed {
        logic                   hit;
        logic                   have_free;
        idx_t                   free_slot;
        idx_t                   oldest_slot;
        logic [TABLE_DEPTH-1:0] expired;
    } scan_result_t;

    // Number of set valid bits, masked to the width of the result field
    function automatic logic [HELD_W-1:0] count_held(input logic [TABLE_DEPTH-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return HELD_W'(n);
    endfunction

endpackage

### design/dpf_if.sv
// Handshake channels of the duplicate packet filter: packet, result and configuration.
interface dpf_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_id;
    logic [31:0] source_id;
    logic [31:0] now_ms;

    modport source (output valid, packet_id, source_id, now_ms, input ready);
    modport sink   (input valid, packet_id, source_id, now_ms, output ready);
endinterface

interface dpf_res_if import dpf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_duplicate;
    logic [HELD_W-1:0] entries_held;
    logic              table_overflow;

    modport source (output valid, is_duplicate, entries_held, table_overflow, input ready);
    modport sink   (input valid, is_duplicate, entries_held, table_overflow, output ready);
endinterface

interface dpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] timeout_ms;

    modport source (output valid, timeout_ms, input ready);
    modport sink   (input valid, timeout_ms, output ready);
endinterface

### design/dpf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module dpf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/dpf_scan.sv
// Scan unit: evaluate one table entry per cycle for match, expiry, free slot and oldest age.
module dpf_scan import dpf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  logic         eval,
    input  idx_t         eval_idx,
    input  entry_t       ent,
    input  logic         ent_valid,
    input  item_t        key,
    input  logic [31:0]  timeout_ms,
    output scan_result_t result
);

    logic                   hit_reg, hit_next;
    logic                   have_free_reg, have_free_next;
    logic                   have_oldest_reg, have_oldest_next;
    idx_t                   free_slot_reg, free_slot_next;
    idx_t                   oldest_slot_reg, oldest_slot_next;
    logic [31:0]            oldest_age_reg, oldest_age_next;
    logic [TABLE_DEPTH-1:0] expired_reg, expired_next;

    logic [31:0] age;
    logic        is_match;
    logic        is_expired;

    always_comb
    begin
        // wrapping age, modulo two to the thirty-two
        age        = key.now_ms - ent.stamp;
        is_match   = ent_valid && (ent.packet_id == key.packet_id)
                     && (ent.source_id == key.source_id);
        is_expired = ent_valid && (age > timeout_ms);

        hit_next         = hit_reg;
        have_free_next   = have_free_reg;
        have_oldest_next = have_oldest_reg;
        free_slot_next   = free_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        oldest_age_next  = oldest_age_reg;
        expired_next     = expired_reg;

        if (clear)
        begin
            hit_next         = 1'b0;
            have_free_next   = 1'b0;
            have_oldest_next = 1'b0;
        end
        else if (eval)
        begin
            expired_next[eval_idx] = is_expired;
            if (is_match)
            begin
                hit_next = 1'b1;
            end
            if (!ent_valid || is_expired)
            begin
                // take the lowest free index only
                if (!have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_slot_next = eval_idx;
                end
            end
            else if (!have_oldest_reg || (age > oldest_age_reg))
            begin
                have_oldest_next = 1'b1;
                oldest_slot_next = eval_idx;
                oldest_age_next  = age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg         <= 1'b0;
            have_free_reg   <= 1'b0;
            have_oldest_reg <= 1'b0;
        end
        else
        begin
            hit_reg         <= hit_next;
            have_free_reg   <= have_free_next;
            have_oldest_reg <= have_oldest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_slot_reg   <= free_slot_next;
        oldest_slot_reg <= oldest_slot_next;
        oldest_age_reg  <= oldest_age_next;
        expired_reg     <= expired_next;
    end

    assign result.hit         = hit_reg;
    assign result.have_free   = have_free_reg;
    assign result.free_slot   = free_slot_reg;
    assign result.oldest_slot = oldest_slot_reg;
    assign result.expired     = expired_reg;

endmodule

### design/duplicate_packet_filter_top.sv
// A packet word is taken only in idle; the scan then walks the single read port of the entry
//   memory one entry per cycle, and the commit registers the result word once the result
//   register is free or being emptied; only then is a new packet taken.
// The result register holds a finished word while the next packet is already being scanned.
// Reset: asynchronous, active low; clears all valid bits at once, timeout returns to 30000 ms.
module duplicate_packet_filter_top import dpf_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    dpf_pkt_if.sink         pkt,
    dpf_res_if.source       res,
    dpf_cfg_if.sink         cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   eval_vld_reg, eval_vld_next;
    idx_t                   eval_idx_reg, eval_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]            timeout_reg, timeout_next;
    result_t                res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    logic                   accept;
    logic                   commit;
    logic                   rd_en;
    idx_t                   rd_addr;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                 rd_entry;
    entry_t                 wr_entry;
    logic                   ram_we;
    idx_t                   slot;
    logic [TABLE_DEPTH-1:0] miss_valid;
    scan_result_t           scan;

    // Entry memory: identifier, source and stamp of each slot; valid bits live in flops here
    dpf_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    dpf_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .eval       (eval_vld_reg),
        .eval_idx   (eval_idx_reg),
        .ent        (rd_entry),
        .ent_valid  (valid_reg[eval_idx_reg]),
        .key        (item_reg),
        .timeout_ms (timeout_reg),
        .result     (scan)
    );

    // Packets are taken only between scans; configuration words are always taken
    assign pkt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = pkt.valid && pkt.ready;

    // Issue one read per cycle; the registered data is evaluated in the cycle after its read
    assign rd_en   = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(TABLE_DEPTH));
    assign rd_addr = cnt_reg[IDX_W-1:0];

    // Commit once the result register is free, or is being emptied this cycle
    assign commit = (state_reg == S_COMMIT) && (!res_valid_reg || res.ready);

    // Lowest free slot after ageing, otherwise the oldest live entry is replaced
    assign slot   = scan.have_free ? scan.free_slot : scan.oldest_slot;
    assign ram_we = commit && !scan.hit;

    assign wr_entry.packet_id = item_reg.packet_id;
    assign wr_entry.source_id = item_reg.source_id;
    assign wr_entry.stamp     = item_reg.now_ms;

    // On a miss: drop expired entries, then mark the written slot
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            miss_valid[i] = (valid_reg[i] && !scan.expired[i]) || (slot == IDX_W'(i));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        timeout_next   = timeout_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        eval_vld_next  = rd_en;
        eval_idx_next  = rd_addr;

        if (cfg.valid)
        begin
            timeout_next = cfg.timeout_ms;
        end

        // Drop the result word once the sink takes it
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next.packet_id = pkt.packet_id;
                    item_next.source_id = pkt.source_id;
                    item_next.now_ms    = pkt.now_ms;
                    cnt_next            = '0;
                    state_next          = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // Last entry is evaluated at this edge
                if ((cnt_reg == CNT_W'(TABLE_DEPTH)) && eval_vld_reg)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    // A hit leaves the table untouched, expired entries included
                    if (!scan.hit)
                    begin
                        valid_next = miss_valid;
                    end
                    res_next.is_duplicate   = scan.hit;
                    res_next.entries_held   = count_held(scan.hit ? valid_reg : miss_valid);
                    res_next.table_overflow = !scan.hit && !scan.have_free;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            valid_reg     <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            eval_vld_reg  <= eval_vld_next;
            valid_reg     <= valid_next;
            timeout_reg   <= timeout_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        eval_idx_reg <= eval_idx_next;
        res_reg      <= res_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.is_duplicate   = res_reg.is_duplicate;
    assign res.entries_held   = res_reg.entries_held;
    assign res.table_overflow = res_reg.table_overflow;

    // A duplicate never replaces an entry
    a_dup_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.is_duplicate && res.table_overflow))
        else $error("duplicate word reports an overflow");

    // A recorded miss leaves at least its own entry held
    a_miss_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.is_duplicate) |-> (res.entries_held != '0))
        else $error("miss word reports an empty table");

    // Overflow only when the whole table stays occupied
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.table_overflow) |-> (res.entries_held == HELD_W'(TABLE_DEPTH)))
        else $error("overflow with a table that is not full");

    // The entry memory is written only when a missed packet is committed
    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (res_valid_reg && !res_reg.is_duplicate && (state_reg == S_IDLE)))
        else $error("entry written outside a miss commit");

endmodule

### dv/duplicate_packet_filter_top_tb.sv
// Self-checking testbench of the duplicate packet filter: predicts and checks each result word.
`timescale 1ns / 100ps

module duplicate_packet_filter_top_tb;
    import dpf_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 3;
    localparam int PAIR_POOL   = 24;
    localparam int PHASE_WORDS = 200;
    localparam int SETTLE_TICKS = 2 * (TABLE_DEPTH + 3);

    // Tracks which (packet_id, source_id) pairs the block should be holding and
    // queues the verdict each accepted packet word must produce.
    class seen_pair_scoreboard;
        bit          slot_live [TABLE_DEPTH];
        bit [31:0]   slot_pid  [TABLE_DEPTH];
        bit [31:0]   slot_src  [TABLE_DEPTH];
        bit [31:0]   slot_stamp[TABLE_DEPTH];
        bit [31:0]   timeout_ms;
        result_t     pending_verdicts[$];
        int          mismatches;
        int          verdicts_checked;
        int          duplicates_seen;
        int          overflows_seen;

        function new();
            timeout_ms = TIMEOUT_RESET;
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
            end
            mismatches       = 0;
            verdicts_checked = 0;
            duplicates_seen  = 0;
            overflows_seen   = 0;
        endfunction

        function void note_packet(item_t p);
            result_t   verdict;
            bit        hit;
            bit        found_free;
            bit        found_live;
            bit        replaced;
            int        target;
            int        oldest;
            int        held;
            bit [31:0] age;
            bit [31:0] oldest_age;

            hit        = 1'b0;
            found_free = 1'b0;
            found_live = 1'b0;
            replaced   = 1'b0;
            target     = 0;
            oldest     = 0;
            oldest_age = '0;
            held       = 0;

            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_live[i] && slot_pid[i] == p.packet_id && slot_src[i] == p.source_id)
                begin
                    hit = 1'b1;
                end
            end

            // a miss ages the table first, then takes a free slot or evicts the oldest
            if (!hit)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    age = p.now_ms - slot_stamp[i];
                    if (slot_live[i] && age > timeout_ms)
                    begin
                        slot_live[i] = 1'b0;
                    end
                end
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!slot_live[i])
                    begin
                        if (!found_free)
                        begin
                            target     = i;
                            found_free = 1'b1;
                        end
                    end
                    else
                    begin
                        age = p.now_ms - slot_stamp[i];
                        if (!found_live || age > oldest_age)
                        begin
                            oldest     = i;
                            oldest_age = age;
                            found_live = 1'b1;
                        end
                    end
                end
                if (!found_free)
                begin
                    target   = oldest;
                    replaced = 1'b1;
                end
                slot_live[target]  = 1'b1;
                slot_pid[target]   = p.packet_id;
                slot_src[target]   = p.source_id;
                slot_stamp[target] = p.now_ms;
            end

            foreach (slot_live[i])
            begin
                held += slot_live[i];
            end
            verdict.is_duplicate   = hit;
            verdict.entries_held   = HELD_W'(held);
            verdict.table_overflow = replaced;
            pending_verdicts.insert(pending_verdicts.size(), verdict);
        endfunction

        function void check_verdict(result_t got);
            result_t want;

            if (pending_verdicts.size() == 0)
            begin
                $error("result word with no packet outstanding: dup %0d held %0d overflow %0d",
                       got.is_duplicate, got.entries_held, got.table_overflow);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            duplicates_seen += want.is_duplicate;
            overflows_seen  += want.table_overflow;
            if (got.is_duplicate !== want.is_duplicate)
            begin
                $error("is_duplicate: expected %0d, got %0d", want.is_duplicate, got.is_duplicate);
                mismatches++;
            end
            if (got.entries_held !== want.entries_held)
            begin
                $error("entries_held: expected %0d, got %0d", want.entries_held, got.entries_held);
                mismatches++;
            end
            if (got.table_overflow !== want.table_overflow)
            begin
                $error("table_overflow: expected %0d, got %0d",
                       want.table_overflow, got.table_overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dpf_pkt_if pkt_ch ();
    dpf_res_if res_ch ();
    dpf_cfg_if cfg_ch ();

    duplicate_packet_filter_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    seen_pair_scoreboard verdicts = new();

    // Sender burst state, and the network clock that the packet words carry
    int        burst_left = 0;
    int        timeouts_programmed = 0;
    bit [31:0] net_time_ms = '0;
    bit [31:0] pool_pid[PAIR_POOL];
    bit [31:0] pool_src[PAIR_POOL];

    // Receiver stall pattern: rotate through a 16-bit mask, redrawn now and then
    logic [15:0] stall_mask  = 16'hFFFF;
    int          stall_phase = 0;
    int          stall_left  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hold ready on the result channel according to the current mask; switch
    // between free flow, a random mask and a sparse one-in-sixteen mask.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_mask = 16'hFFFF;
                1:       stall_mask = 16'($urandom) | 16'h0001;
                default: stall_mask = 16'h0001 << $urandom_range(0, 15);
            endcase
            stall_left = $urandom_range(32, 256);
        end
        stall_left--;
        res_ch.ready = stall_mask[stall_phase];
        stall_phase  = (stall_phase + 1) % 16;
    end

    // Check every result word the block hands over
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.is_duplicate   = res_ch.is_duplicate;
            got.entries_held   = res_ch.entries_held;
            got.table_overflow = res_ch.table_overflow;
            verdicts.check_verdict(got);
        end
    end

    function automatic item_t packet_word(bit [31:0] pid, bit [31:0] src, bit [31:0] now);
        item_t p;
        p.packet_id = pid;
        p.source_id = src;
        p.now_ms    = now;
        return p;
    endfunction

    // Offer one packet word; between bursts drop valid for a random gap first.
    // Valid stays high from one word to the next inside a burst.
    task automatic send_packet(item_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 30);
            @(negedge clk);
            pkt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        else
        begin
            @(negedge clk);
        end
        pkt_ch.valid     = 1'b1;
        pkt_ch.packet_id = p.packet_id;
        pkt_ch.source_id = p.source_id;
        pkt_ch.now_ms    = p.now_ms;
        do
            @(posedge clk);
        while (!pkt_ch.ready);
        verdicts.note_packet(p);
        burst_left--;
    endtask

    // Drop valid and wait until every verdict owed has come back
    task automatic drain_verdicts();
        @(negedge clk);
        pkt_ch.valid = 1'b0;
        burst_left   = 0;
        while (verdicts.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Write the timeout register; only called with the block idle
    task automatic program_timeout(bit [31:0] value);
        drain_verdicts();
        @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.timeout_ms = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        verdicts.timeout_ms = value;
        timeouts_programmed++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Hand-picked words at the reset timeout: field extremes, a hit, pairs
    // sharing one half, an expired entry that still matches, a full table with
    // eviction ties, and aging across the 32-bit wrap of the clock.
    task automatic run_directed();
        send_packet(packet_word(32'h0000_0000, 32'h0000_0000, 32'd0));
        send_packet(packet_word(32'h0000_0000, 32'h0000_0000, 32'd5));
        send_packet(packet_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100));
        send_packet(packet_word(32'h0000_0000, 32'hFFFF_FFFF, 32'd200));
        send_packet(packet_word(32'hFFFF_FFFF, 32'h0000_0000, 32'd300));
        // seventeen more misses at one instant: fill the free slots, then evict
        // the four older entries, then break an all-equal-age tie
        for (int i = 1; i <= 17; i++)
        begin
            send_packet(packet_word(32'(i), 32'hA5A5_A5A5, 32'd1000));
        end
        // long past the timeout, yet a hit does no aging
        send_packet(packet_word(32'd5, 32'hA5A5_A5A5, 32'd40000));
        send_packet(packet_word(32'h0000_1234, 32'h0000_5678, 32'h0000_0010));
        send_packet(packet_word(32'h0000_4321, 32'h0000_8765, 32'hFFFF_FFF0));
        send_packet(packet_word(32'h0000_CAFE, 32'h0000_BEEF, 32'h0000_0005));
        net_time_ms = 32'h0000_0005;
    endtask

    // Random words at one timeout: mostly pairs from a pool larger than the
    // table so hits, aging and evictions all happen, with noise mixed in.
    task automatic run_aging_phase(bit [31:0] timeout, int words);
        bit [31:0] step;
        bit [31:0] pid;
        bit [31:0] src;
        int        pick;

        program_timeout(timeout);
        for (int i = 0; i < PAIR_POOL; i++)
        begin
            // odd entries share the identifier of their neighbour
            pool_pid[i] = (i % 2 == 1) ? pool_pid[i - 1] : $urandom;
            pool_src[i] = $urandom;
        end
        for (int n = 0; n < words; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: step = $urandom_range(0, 63);
                5, 6:          step = timeout >> $urandom_range(1, 6);
                7, 8:          step = timeout - 32'd1 + $urandom_range(0, 2);
                default:       step = $urandom;
            endcase
            net_time_ms += step;
            pick = $urandom_range(0, PAIR_POOL - 1);
            case ($urandom_range(0, 19))
                0, 1:    begin pid = $urandom;        src = $urandom;        end
                2:       begin pid = pool_pid[pick];  src = $urandom;        end
                default: begin pid = pool_pid[pick];  src = pool_src[pick];  end
            endcase
            send_packet(packet_word(pid, src, net_time_ms));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        pkt_ch.valid      = 1'b0;
        pkt_ch.packet_id  = '0;
        pkt_ch.source_id  = '0;
        pkt_ch.now_ms     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.timeout_ms = '0;
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        // walk the timeout through both extremes and a spread in between
        run_aging_phase(32'd0, PHASE_WORDS);
        run_aging_phase(32'hFFFF_FFFF, PHASE_WORDS);
        run_aging_phase(32'd30000, PHASE_WORDS);
        run_aging_phase($urandom_range(1, 200), PHASE_WORDS);
        run_aging_phase($urandom, PHASE_WORDS);
        run_aging_phase(32'd5000, PHASE_WORDS);

        drain_verdicts();
        // catch any stray word after the last expected one
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Checked %0d verdicts over %0d timeout settings: %0d duplicates, %0d evictions.",
                 verdicts.verdicts_checked, timeouts_programmed + 1,
                 verdicts.duplicates_seen, verdicts.overflows_seen);
        $display("Field mismatches: %0d.", verdicts.mismatches);
        if (verdicts.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Stop a run that hangs on a handshake
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
